[design/doip_uds_request_responder_assert.svh]
`ifndef DOIP_UDS_REQUEST_RESPONDER_ASSERT_SVH
`define DOIP_UDS_REQUEST_RESPONDER_ASSERT_SVH
// implication checked every clock outside reset
`define DUR_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// next-cycle implication
`define DUR_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

[design/dur_pkg.sv]
package dur_pkg;

    localparam int FRAME_LIMIT = 64;
    localparam int HEAD_DEPTH = 18;
    localparam int LEN_W = 5;

    localparam logic [15:0] ECU_RESET = 16'h0201;

    // doip payload types
    localparam logic [15:0] PT_ROUTING = 16'h0005;
    localparam logic [15:0] PT_DIAG = 16'h8001;

    // uds services and codes
    localparam logic [7:0] SID_SESSION = 8'h10;
    localparam logic [7:0] SID_READ_DTC = 8'h19;
    localparam logic [7:0] SID_READ_DID = 8'h22;
    localparam logic [7:0] SID_WRITE_DID = 8'h2E;
    localparam logic [7:0] SID_IO_CTRL = 8'h2F;
    localparam logic [7:0] RSP_BIT = 8'h40;
    localparam logic [7:0] NEG_RSP = 8'h7F;
    localparam logic [7:0] NRC_NOT_SUPPORTED = 8'h11;
    localparam logic [7:0] NRC_SUB_FUNC = 8'h12;
    localparam logic [7:0] NRC_LENGTH = 8'h13;
    localparam logic [7:0] NRC_RANGE = 8'h31;
    localparam logic [7:0] NRC_SESSION = 8'h7E;
    localparam logic [7:0] SUB_DEFAULT = 8'h01;
    localparam logic [7:0] SUB_EXTENDED = 8'h03;
    localparam logic [7:0] SUB_DTC_MASK = 8'h02;
    localparam logic [7:0] IO_RETURN = 8'h00;
    localparam logic [7:0] IO_ADJUST = 8'h03;
    localparam logic [15:0] DID_THRESHOLD = 16'h2001;
    localparam logic [15:0] DID_MOTOR = 16'h4000;
    localparam logic [15:0] THR_MAX = 16'd500;
    localparam logic [7:0] SPEED_MAX = 8'd100;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_OPEN  = 2'd1,
        OP_CLOSE = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // one answer job handed from front to back
    typedef struct packed {
        logic             close;
        logic [LEN_W-1:0] len;
        logic [15:0]      sa;
        logic [7:0]       u0;
        logic [7:0]       u1;
        logic [7:0]       u2;
        logic [7:0]       u3;
        logic [7:0]       u4;
        logic             routing;
        logic             sess;
        logic             ovr;
        logic             dir;
        logic [6:0]       spd;
        logic [8:0]       thr;
    } t_job;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_SEND = 1'b1
    } t_state;

endpackage

[design/dur_front.sv]
module dur_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [1:0]     i_operation,
    input  logic [7:0]     i_rx_byte,
    output logic           o_job_valid,
    input  logic           i_job_ready,
    output dur_pkg::t_job  o_job
);

    logic [7:0]  r_head [dur_pkg::HEAD_DEPTH];
    logic [32:0] r_seen, n_seen;
    logic [31:0] r_plen, n_plen;
    logic        r_closing, n_closing;
    logic        r_sess, n_sess;
    logic        r_ovr, n_ovr;
    logic        r_dir, n_dir;
    logic [6:0]  r_spd, n_spd;
    logic [8:0]  r_thr, n_thr;
    logic        acc;
    logic        emit;
    logic [7:0]  d [dur_pkg::HEAD_DEPTH];
    dur_pkg::t_job job;
    logic [31:0] dl;
    logic [15:0] did, raw;
    logic [7:0]  sid;

    assign o_stall = !i_job_ready;
    assign acc = i_valid && i_job_ready;

    always_ff @(posedge i_clk) begin
        if (acc && i_operation == dur_pkg::OP_BYTE && !r_closing
                && r_seen < 33'(dur_pkg::HEAD_DEPTH)) begin
            r_head[r_seen[4:0]] <= i_rx_byte;
        end
    end

    // current view of the head including this byte
    always_comb begin
        for (int k = 0; k < dur_pkg::HEAD_DEPTH; k++) begin
            d[k] = (r_seen == 33'(k)) ? i_rx_byte : r_head[k];
        end
    end

    always_comb begin
        n_seen = r_seen; n_plen = r_plen; n_closing = r_closing;
        n_sess = r_sess; n_ovr = r_ovr; n_dir = r_dir; n_spd = r_spd; n_thr = r_thr;
        emit = 1'b0;
        job = '0;
        dl = '0; did = '0; raw = '0; sid = '0;
        unique case (dur_pkg::t_op'(i_operation))
            dur_pkg::OP_OPEN: begin
                n_seen = '0; n_plen = '0; n_closing = 1'b0;
            end
            dur_pkg::OP_CLOSE: begin
                n_seen = '0; n_closing = 1'b1;
                emit = 1'b1; job.close = 1'b1;
            end
            dur_pkg::OP_BYTE: begin
                if (!r_closing) begin
                    n_seen = r_seen + 33'd1;
                    if (n_seen == 33'd8) begin
                        n_plen = {d[4], d[5], d[6], d[7]};
                    end
                    if (n_seen >= 33'd8 && n_seen == 33'd8 + {1'b0, n_plen}) begin
                        n_seen = '0;
                        emit = 1'b1;
                        job.sa = {d[8], d[9]};
                        sid = d[12];
                        dl = n_plen - 32'd4;
                        did = {d[13], d[14]};
                        raw = {d[15], d[16]};
                        job.u0 = dur_pkg::NEG_RSP; job.u1 = sid; job.len = 5'd15;
                        if ({1'b0, n_plen} + 33'd8 > 33'(dur_pkg::FRAME_LIMIT)) begin
                            job.close = 1'b1;
                        end else if ({d[2], d[3]} == dur_pkg::PT_ROUTING) begin
                            if (n_plen < 32'd7) job.close = 1'b1;
                            else begin
                                job.routing = 1'b1; job.len = 5'd19;
                            end
                        end else if ({d[2], d[3]} == dur_pkg::PT_DIAG && n_plen >= 32'd5) begin
                            priority case (sid)
                                dur_pkg::SID_SESSION: begin
                                    if (dl < 32'd2) job.u2 = dur_pkg::NRC_LENGTH;
                                    else if (d[13] != dur_pkg::SUB_EXTENDED
                                             && d[13] != dur_pkg::SUB_DEFAULT)
                                        job.u2 = dur_pkg::NRC_SUB_FUNC;
                                    else begin
                                        n_sess = (d[13] == dur_pkg::SUB_EXTENDED);
                                        n_ovr = 1'b0; n_dir = 1'b0; n_spd = '0;
                                        job.u0 = dur_pkg::SID_SESSION | dur_pkg::RSP_BIT;
                                        job.u1 = d[13]; job.len = 5'd14;
                                    end
                                end
                                dur_pkg::SID_READ_DTC: begin
                                    if (dl < 32'd3) job.u2 = dur_pkg::NRC_LENGTH;
                                    else if (d[13] != dur_pkg::SUB_DTC_MASK)
                                        job.u2 = dur_pkg::NRC_SUB_FUNC;
                                    else begin
                                        job.u0 = dur_pkg::SID_READ_DTC | dur_pkg::RSP_BIT;
                                        job.u1 = dur_pkg::SUB_DTC_MASK; job.u2 = 8'h00;
                                        job.u3 = d[14]; job.len = 5'd16;
                                    end
                                end
                                dur_pkg::SID_WRITE_DID: begin
                                    if (dl < 32'd5) job.u2 = dur_pkg::NRC_LENGTH;
                                    else if (!r_sess) job.u2 = dur_pkg::NRC_SESSION;
                                    else if (did != dur_pkg::DID_THRESHOLD || raw < 16'd1
                                             || raw > dur_pkg::THR_MAX)
                                        job.u2 = dur_pkg::NRC_RANGE;
                                    else begin
                                        n_thr = raw[8:0];
                                        job.u0 = dur_pkg::SID_WRITE_DID | dur_pkg::RSP_BIT;
                                        job.u1 = dur_pkg::DID_THRESHOLD[15:8];
                                        job.u2 = dur_pkg::DID_THRESHOLD[7:0];
                                    end
                                end
                                dur_pkg::SID_READ_DID: begin
                                    if (dl < 32'd3) job.u2 = dur_pkg::NRC_LENGTH;
                                    else if (did != dur_pkg::DID_THRESHOLD)
                                        job.u2 = dur_pkg::NRC_RANGE;
                                    else begin
                                        job.u0 = dur_pkg::SID_READ_DID | dur_pkg::RSP_BIT;
                                        job.u1 = dur_pkg::DID_THRESHOLD[15:8];
                                        job.u2 = dur_pkg::DID_THRESHOLD[7:0];
                                        job.u3 = {7'd0, r_thr[8]}; job.u4 = r_thr[7:0];
                                        job.len = 5'd17;
                                    end
                                end
                                dur_pkg::SID_IO_CTRL: begin
                                    if (dl < 32'd4) job.u2 = dur_pkg::NRC_LENGTH;
                                    else if (!r_sess) job.u2 = dur_pkg::NRC_SESSION;
                                    else if (did != dur_pkg::DID_MOTOR) job.u2 = dur_pkg::NRC_RANGE;
                                    else if (d[15] == dur_pkg::IO_ADJUST && dl < 32'd6)
                                        job.u2 = dur_pkg::NRC_LENGTH;
                                    else if (d[15] == dur_pkg::IO_ADJUST
                                             || d[15] == dur_pkg::IO_RETURN) begin
                                        if (d[15] == dur_pkg::IO_ADJUST) begin
                                            n_ovr = 1'b1; n_dir = (d[16] != 8'h00);
                                            n_spd = (d[17] > dur_pkg::SPEED_MAX)
                                                    ? dur_pkg::SPEED_MAX[6:0] : d[17][6:0];
                                        end else begin
                                            n_ovr = 1'b0; n_dir = 1'b0; n_spd = '0;
                                        end
                                        job.u0 = dur_pkg::SID_IO_CTRL | dur_pkg::RSP_BIT;
                                        job.u1 = dur_pkg::DID_MOTOR[15:8];
                                        job.u2 = dur_pkg::DID_MOTOR[7:0];
                                    end else job.u2 = dur_pkg::NRC_SUB_FUNC;
                                end
                                default: job.u2 = dur_pkg::NRC_NOT_SUPPORTED;
                            endcase
                        end else begin
                            job.close = 1'b1;
                        end
                        if (job.close) n_closing = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        job.sess = n_sess; job.ovr = n_ovr; job.dir = n_dir;
        job.spd = n_spd; job.thr = n_thr;
    end

    assign o_job_valid = acc && emit;
    assign o_job = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0; r_plen <= '0; r_closing <= 1'b0; r_sess <= 1'b0;
            r_ovr <= 1'b0; r_dir <= 1'b0; r_spd <= '0; r_thr <= '0;
        end else if (acc) begin
            r_seen <= n_seen; r_plen <= n_plen; r_closing <= n_closing; r_sess <= n_sess;
            r_ovr <= n_ovr; r_dir <= n_dir; r_spd <= n_spd; r_thr <= n_thr;
        end
    end

endmodule

[design/dur_queue.sv]
module dur_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  dur_pkg::t_job  i_data,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_rd,
    output dur_pkg::t_job  o_data
);

    dur_pkg::t_job r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          wr, rd;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign wr = i_wr && o_ready;
    assign rd = i_rd && o_valid;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule

[design/dur_back.sv]
module dur_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [15:0]    i_ecu,
    input  logic           i_job_valid,
    output logic           o_job_take,
    input  dur_pkg::t_job  i_job,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [7:0]     o_tx_byte,
    output logic           o_tx_last,
    output logic           o_close_request,
    output logic           o_session_active,
    output logic           o_override_active,
    output logic           o_motor_direction,
    output logic [6:0]     o_motor_speed,
    output logic [8:0]     o_stop_threshold
);

    dur_pkg::t_state r_state, n_state;
    logic [4:0] r_idx, n_idx;
    logic [7:0] b;
    logic       last;
    logic       fire;

    assign fire = o_valid && !i_stall;
    assign last = i_job.close || (r_idx == i_job.len - 5'd1);

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        unique case (r_state)
            dur_pkg::ST_IDLE: if (i_job_valid) n_state = dur_pkg::ST_SEND;
            dur_pkg::ST_SEND: if (fire) begin
                if (last) begin
                    n_state = dur_pkg::ST_IDLE;
                    n_idx = '0;
                end else n_idx = r_idx + 5'd1;
            end
            default: n_state = dur_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        b = 8'h00;
        if (i_job.routing) begin
            unique case (r_idx)
                5'd0: b = 8'h03;  5'd1: b = 8'hFC;  5'd3: b = 8'h06;  5'd7: b = 8'h0B;
                5'd8: b = i_ecu[15:8];  5'd9: b = i_ecu[7:0];
                5'd10: b = i_job.sa[15:8];  5'd11: b = i_job.sa[7:0];
                5'd12: b = 8'h10;
                default: b = 8'h00;
            endcase
        end else begin
            unique case (r_idx)
                5'd0: b = 8'h03;  5'd1: b = 8'hFC;  5'd2: b = 8'h80;  5'd3: b = 8'h01;
                5'd7: b = 8'(i_job.len - 5'd8);
                5'd8: b = i_ecu[15:8];  5'd9: b = i_ecu[7:0];
                5'd10: b = i_job.sa[15:8];  5'd11: b = i_job.sa[7:0];
                5'd12: b = i_job.u0;  5'd13: b = i_job.u1;  5'd14: b = i_job.u2;
                5'd15: b = i_job.u3;  5'd16: b = i_job.u4;
                default: b = 8'h00;
            endcase
        end
        if (i_job.close) b = 8'h00;
    end

    always_comb begin
        o_valid = (r_state == dur_pkg::ST_SEND) && i_job_valid;
        o_job_take = fire && last;
        o_tx_byte = b;
        o_tx_last = last;
        o_close_request = i_job.close;
        o_session_active = i_job.sess;
        o_override_active = i_job.ovr;
        o_motor_direction = i_job.dir;
        o_motor_speed = i_job.spd;
        o_stop_threshold = i_job.thr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dur_pkg::ST_IDLE;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
        end
    end

endmodule

[design/doip_uds_request_responder.sv]
// DoIP/UDS responder for one diagnostic connection. Each received byte, open or
// peer close is one request on i_valid/o_stall, taken while o_stall is low; a
// finished frame queues an answer job (two-deep queue) and the back end, after
// an idle state per job, plays it out one byte per cycle while i_stall is low on
// o_valid/i_stall: 19 bytes for routing activation, 14 to 17 for UDS, one result
// for a close. Frames overlap with sending until the queue fills. i_cfg_data
// (ecu address) is written over i_cfg_valid/o_cfg_ready.
`include "doip_uds_request_responder_assert.svh"
module doip_uds_request_responder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_tx_byte,
    output logic        o_tx_last,
    output logic        o_close_request,
    output logic        o_session_active,
    output logic        o_override_active,
    output logic        o_motor_direction,
    output logic [6:0]  o_motor_speed,
    output logic [8:0]  o_stop_threshold
);

    logic [15:0]   r_ecu;
    logic          f_valid, q_ready, q_valid, q_take;
    dur_pkg::t_job f_job, q_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ecu <= dur_pkg::ECU_RESET;
        else if (i_cfg_valid) r_ecu <= i_cfg_data;
    end

    dur_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_operation, .i_rx_byte,
        .o_job_valid(f_valid), .i_job_ready(q_ready), .o_job(f_job)
    );

    dur_queue u_queue (
        .i_clk, .i_rst_n, .i_wr(f_valid), .i_data(f_job), .o_ready(q_ready),
        .o_valid(q_valid), .i_rd(q_take), .o_data(q_job)
    );

    dur_back u_back (
        .i_clk, .i_rst_n, .i_ecu(r_ecu),
        .i_job_valid(q_valid), .o_job_take(q_take), .i_job(q_job),
        .o_valid, .i_stall, .o_tx_byte, .o_tx_last, .o_close_request,
        .o_session_active, .o_override_active, .o_motor_direction,
        .o_motor_speed, .o_stop_threshold
    );

    `DUR_ASSERT_IMP(a_close_last, i_clk, i_rst_n, o_valid && o_close_request, o_tx_last)
    `DUR_ASSERT_IMP(a_speed_max, i_clk, i_rst_n, o_valid, o_motor_speed <= 7'd100)
    `DUR_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, !q_ready, o_stall && q_valid)

endmodule
